>>> design/cclacc_pkg.sv
package cclacc_pkg;

  localparam int unsigned InW     = 16;
  localparam int unsigned ChainW  = 35;
  localparam int unsigned TotalW  = 53;
  localparam int unsigned PointsW = 11;
  localparam int unsigned SegW    = 25;
  localparam int unsigned RadW    = 64;
  localparam int unsigned RootW   = 32;
  localparam int unsigned OutDataW = 104;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_CHECK,
    S_CROSS,
    S_DECIDE,
    S_SIZE,
    S_SQUARE,
    S_ROOT_INIT,
    S_ROOT,
    S_PUSH,
    S_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic prep;
    logic base;
    logic rd;
    logic xprod;
    logic pop;
    logic size;
    logic square;
    logic root_init;
    logic root_step;
    logic push;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_ge2;
    logic cnt_full;
    logic non_left;
    logic root_last;
    logic out_free;
  } sts_t;

endpackage

>>> design/convex_chain_length_accumulator_top.sv
// Per input word: a base point (empty stack) is stored directly; otherwise each
// popped point takes a memory read, a cross product and a decision, and a kept
// point is sized, squared, square-rooted and pushed; a dropped point is not.
// A new word is accepted only after the last result is committed; the 32-step
// bit-serial square root and the one-read-port stack memory limit the rate.
// Reset (rst_ni low, async) empties the stack and clears chain and total.
module convex_chain_length_accumulator_top #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // point_x[15:0], point_y[31:16]
  input  logic [1:0]   s_axis_tuser,   // start_chain[0], accumulate[1]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // chain_length[34:0], total_length[87:35],
                                       // chain_points[98:88], zero pad
  output logic [0:0]   m_axis_tuser    // overflow[0]
);
  import cclacc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cclacc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  cclacc_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

>>> design/cclacc_ctrl.sv
module cclacc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  cclacc_pkg::sts_t  sts_i,
  output cclacc_pkg::cmd_t  cmd_o
);
  import cclacc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.accept = 1'b1;
          state_d      = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.prep = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.cnt_zero) begin
          cmd_o.base = 1'b1;
          state_d    = S_DONE;
        end else if (sts_i.cnt_ge2) begin
          cmd_o.rd = 1'b1;
          state_d  = S_CROSS;
        end else begin
          state_d = S_SIZE;
        end
      end
      S_CROSS: begin
        cmd_o.xprod = 1'b1;
        state_d     = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.non_left) begin
          cmd_o.pop = 1'b1;
          state_d   = S_CHECK;
        end else begin
          state_d = S_SIZE;
        end
      end
      S_SIZE: begin
        cmd_o.size = 1'b1;
        state_d    = sts_i.cnt_full ? S_DONE : S_SQUARE;
      end
      S_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = S_ROOT_INIT;
      end
      S_ROOT_INIT: begin
        cmd_o.root_init = 1'b1;
        state_d         = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (sts_i.root_last) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/cclacc_dp.sv
module cclacc_dp #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [2*cclacc_pkg::InW-1:0]        s_axis_tdata,
  input  logic [1:0]                          s_axis_tuser,
  input  cclacc_pkg::cmd_t                    cmd_i,
  output cclacc_pkg::sts_t                    sts_o,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [cclacc_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic [0:0]                          m_axis_tuser
);
  import cclacc_pkg::*;

  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned DW    = CW + 1;
  localparam int unsigned PW    = 2 * DW;
  localparam int unsigned XW    = PW + 1;
  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned ENT_W = 2 * CW + SegW;

  // input word, sign extended and cut to the coordinate width
  logic signed [31:0] in_x32, in_y32;
  assign in_x32 = 32'($signed(s_axis_tdata[InW-1:0]));
  assign in_y32 = 32'($signed(s_axis_tdata[2*InW-1:InW]));

  logic signed [CW-1:0] px_q, py_q, top_x_q, top_y_q;
  logic [SegW-1:0]      top_seg_q;
  logic                 start_q, acc_q, ovf_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [ChainW-1:0]    chain_q;
  logic [TotalW-1:0]    total_q;
  logic [ENT_W-1:0]     mem [MAX_POINTS];
  logic [ENT_W-1:0]     rd_q;
  logic signed [PW-1:0] p1_q, p2_q;
  logic [DW-1:0]        ux_q, uy_q;
  logic [2*DW-1:0]      sq1_q, sq2_q;
  logic [RadW-1:0]      rad_q;
  logic [RootW+1:0]     rem_q;
  logic [RootW-1:0]     root_q;
  logic [4:0]           it_q;
  logic [ChainW-1:0]    out_chain_q;
  logic [TotalW-1:0]    out_total_q;
  logic [PointsW-1:0]   out_cnt_q;
  logic                 out_ovf_q;

  // entry layout: {seg, y, x}
  logic signed [CW-1:0] ax, ay;
  logic [SegW-1:0]      aseg;
  assign ax   = rd_q[CW-1:0];
  assign ay   = rd_q[2*CW-1:CW];
  assign aseg = rd_q[ENT_W-1:2*CW];

  logic signed [DW-1:0] bxa, bya, cxa, cya, dx, dy;
  assign bxa = DW'(top_x_q) - DW'(ax);
  assign bya = DW'(top_y_q) - DW'(ay);
  assign cxa = DW'(px_q) - DW'(ax);
  assign cya = DW'(py_q) - DW'(ay);
  assign dx  = DW'(px_q) - DW'(top_x_q);
  assign dy  = DW'(py_q) - DW'(top_y_q);

  logic signed [XW-1:0] cross_v;
  assign cross_v = XW'(p1_q) - XW'(p2_q);

  logic [CNT_W-1:0] cm2;
  assign cm2 = cnt_q - CNT_W'(2);

  logic [RadW-1:0] sq_sum, rad_init;
  assign sq_sum   = RadW'(sq1_q) + RadW'(sq2_q);
  assign rad_init = sq_sum << (2 * FRAC_BITS);

  // one result bit per step
  logic [RootW+1:0] rem_sh, trial;
  logic             ge;
  assign rem_sh = {rem_q[RootW-1:0], rad_q[RadW-1:RadW-2]};
  assign trial  = {root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  logic [SegW-1:0]     seg_new;
  logic [ChainW:0]     csum;
  logic [TotalW:0]     tsum;
  logic [TotalW-1:0]   total_next;
  assign seg_new    = root_q[SegW-1:0];
  assign csum       = {1'b0, chain_q} + (ChainW + 1)'(seg_new);
  assign tsum       = {1'b0, total_q} + (TotalW + 1)'(chain_q);
  assign total_next = !acc_q ? total_q : (tsum[TotalW] ? '1 : tsum[TotalW-1:0]);

  assign sts_o.cnt_zero  = cnt_q == '0;
  assign sts_o.cnt_ge2   = cnt_q >= CNT_W'(2);
  assign sts_o.cnt_full  = cnt_q >= CNT_W'(MAX_POINTS);
  assign sts_o.non_left  = cross_v[XW-1] || (cross_v == '0);
  assign sts_o.root_last = it_q == 5'd31;
  assign sts_o.out_free  = !m_axis_tvalid || m_axis_tready;

  // stack memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.base) begin
      mem[IDX_W'(0)] <= {SegW'(0), py_q, px_q};
    end else if (cmd_i.push) begin
      mem[cnt_q[IDX_W-1:0]] <= {seg_new, py_q, px_q};
    end
    if (cmd_i.rd) begin
      rd_q <= mem[cm2[IDX_W-1:0]];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      px_q <= in_x32[CW-1:0];
      py_q <= in_y32[CW-1:0];
    end
    if (cmd_i.base) begin
      top_x_q   <= px_q;
      top_y_q   <= py_q;
      top_seg_q <= '0;
    end else if (cmd_i.pop) begin
      top_x_q   <= ax;
      top_y_q   <= ay;
      top_seg_q <= aseg;
    end else if (cmd_i.push) begin
      top_x_q   <= px_q;
      top_y_q   <= py_q;
      top_seg_q <= seg_new;
    end
    if (cmd_i.xprod) begin
      p1_q <= cya * bxa;
      p2_q <= cxa * bya;
    end
    if (cmd_i.size) begin
      ux_q <= dx[DW-1] ? DW'(-dx) : DW'(dx);
      uy_q <= dy[DW-1] ? DW'(-dy) : DW'(dy);
    end
    if (cmd_i.square) begin
      sq1_q <= ux_q * ux_q;
      sq2_q <= uy_q * uy_q;
    end
    if (cmd_i.root_init) begin
      rad_q  <= rad_init;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[RootW-2:0], ge};
    end
    if (cmd_i.commit) begin
      out_chain_q <= chain_q;
      out_total_q <= total_next;
      out_cnt_q   <= PointsW'(cnt_q);
      out_ovf_q   <= ovf_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q       <= 1'b0;
      acc_q         <= 1'b0;
      ovf_q         <= 1'b0;
      cnt_q         <= '0;
      chain_q       <= '0;
      total_q       <= '0;
      it_q          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        start_q <= s_axis_tuser[0];
        acc_q   <= s_axis_tuser[1];
      end
      if (cmd_i.prep) begin
        ovf_q <= 1'b0;
        if (start_q) begin
          cnt_q   <= '0;
          chain_q <= '0;
          total_q <= '0;
        end
      end
      if (cmd_i.base) begin
        cnt_q   <= CNT_W'(1);
        chain_q <= '0;
      end
      if (cmd_i.pop) begin
        cnt_q   <= cnt_q - CNT_W'(1);
        chain_q <= (chain_q >= ChainW'(top_seg_q)) ? chain_q - ChainW'(top_seg_q) : '0;
      end
      if (cmd_i.size && sts_o.cnt_full) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.root_init) begin
        it_q <= '0;
      end else if (cmd_i.root_step) begin
        it_q <= it_q + 5'd1;
      end
      if (cmd_i.push) begin
        cnt_q   <= cnt_q + CNT_W'(1);
        chain_q <= csum[ChainW] ? '1 : csum[ChainW-1:0];
      end
      if (cmd_i.commit) begin
        total_q       <= total_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = {5'd0, out_cnt_q, out_total_q, out_chain_q};
  assign m_axis_tuser = out_ovf_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_POINTS))
    else $error("stack count above depth");
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && ovf_q |-> cnt_q == CNT_W'(MAX_POINTS))
    else $error("overflow flagged with room on the stack");
  a_commit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> cnt_q != '0)
    else $error("result with empty stack");
  a_pop_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> cnt_q >= CNT_W'(2))
    else $error("pop below base point");
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |=> cnt_q == $past(cnt_q) - CNT_W'(1))
    else $error("pop did not shrink stack");
`endif

endmodule

>>> dv/tb_convex_chain_length_accumulator_top.sv
// Keeps its own copy of the convex chain and works out the expected output word
// for each input word the block accepts.
class chain_scoreboard;
  typedef struct packed {
    logic [34:0] chain;
    logic [52:0] total;
    logic [10:0] points;
    logic        ovf;
  } chain_word_t;

  localparam int unsigned MaxPts = 1024;
  localparam longint unsigned ChainMax = (64'd1 << 35) - 1;
  localparam longint unsigned TotalMax = (64'd1 << 53) - 1;

  longint px_q[MaxPts];
  longint py_q[MaxPts];
  longint unsigned seg_q[MaxPts];
  int unsigned depth;
  longint unsigned chain_len;
  longint unsigned total_len;
  chain_word_t pending_q[$];
  int errors;

  function new();
    depth = 0;
    chain_len = 0;
    total_len = 0;
    errors = 0;
  endfunction

  // Bit-serial floor square root on 64 bits.
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned seg_length(longint ax, longint ay, longint bx,
                                                 longint by);
    longint dx;
    longint dy;
    longint unsigned sq;
    dx = bx - ax;
    dy = by - ay;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    sq = longint'(dx * dx) + longint'(dy * dy);
    return floor_sqrt(sq << 16) & ((64'd1 << 25) - 1);
  endfunction

  function void note_point(logic [15:0] x, logic [15:0] y, bit start, bit acc);
    longint cx;
    longint cy;
    longint cr;
    longint unsigned s;
    chain_word_t w;
    cx = longint'($signed(x));
    cy = longint'($signed(y));
    w.ovf = 1'b0;
    if (start) begin
      total_len = 0;
      depth = 0;
      chain_len = 0;
    end
    if (depth == 0) begin
      px_q[0] = cx;
      py_q[0] = cy;
      seg_q[0] = 0;
      depth = 1;
      chain_len = 0;
    end else begin
      while (depth >= 2) begin
        cr = (cy - py_q[depth-2]) * (px_q[depth-1] - px_q[depth-2])
           - (cx - px_q[depth-2]) * (py_q[depth-1] - py_q[depth-2]);
        if (cr > 0) break;
        s = seg_q[depth-1];
        chain_len = (chain_len >= s) ? chain_len - s : 0;
        depth--;
      end
      if (depth >= MaxPts) begin
        w.ovf = 1'b1;
      end else begin
        s = seg_length(px_q[depth-1], py_q[depth-1], cx, cy);
        px_q[depth] = cx;
        py_q[depth] = cy;
        seg_q[depth] = s;
        depth++;
        chain_len += s;
        if (chain_len > ChainMax) chain_len = ChainMax;
      end
    end
    if (acc) begin
      total_len += chain_len;
      if (total_len > TotalMax) total_len = TotalMax;
    end
    w.chain = chain_len[34:0];
    w.total = total_len[52:0];
    w.points = depth[10:0];
    pending_q.insert(pending_q.size(), w);
  endfunction

  function void check_word(logic [103:0] data, logic ovf);
    chain_word_t e;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result word %h", $time, data);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (data[34:0] !== e.chain) begin
      $display("%0t: chain_length exp %0d got %0d", $time, e.chain, data[34:0]);
      errors++;
    end
    if (data[87:35] !== e.total) begin
      $display("%0t: total_length exp %0d got %0d", $time, e.total, data[87:35]);
      errors++;
    end
    if (data[98:88] !== e.points) begin
      $display("%0t: chain_points exp %0d got %0d", $time, e.points, data[98:88]);
      errors++;
    end
    if (ovf !== e.ovf) begin
      $display("%0t: overflow exp %0b got %0b", $time, e.ovf, ovf);
      errors++;
    end
  endfunction
endclass

module tb_convex_chain_length_accumulator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned CycleLimit = 64'd8_000_000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  chain_scoreboard sb;
  longint unsigned cycles = 0;

  convex_chain_length_accumulator_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 120);
  endfunction

  // tvalid stays high after an accept so that back-to-back words need only one
  // assignment per edge; it drops only before a gap and when draining.
  task automatic send_point(logic [15:0] x, logic [15:0] y, bit start, bit acc);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tuser  <= {acc, start};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_point(x, y, start, acc);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Random chain: either wide-range points or a spiral-ish sequence that
  // tends to stay convex and grow the stack.
  task automatic random_run(int n, bit big);
    int i;
    int xv;
    for (i = 0; i < n; i++) begin
      if (big) begin
        send_point(16'($urandom), 16'($urandom), 1'b0, 1'($urandom_range(0, 1)));
      end else begin
        xv = -30000 + i * 60 + $urandom_range(0, 40);
        send_point(16'(xv), 16'((i * i) % 20000 - 10000 + $urandom_range(0, 3)),
                   $urandom_range(0, 30) == 0, $urandom_range(0, 3) != 0);
      end
    end
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tuser[0]);
      m_axis_tready <= ($urandom_range(0, 99) < 70) ||
                       (cycles % 4000 < 300);
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= CycleLimit) begin
      $display("convex_chain_length_accumulator_top regression: fail");
      $finish;
    end
  end

  initial begin
    int i;
    int n;
    int fa[600];
    int fb[600];
    int nf;
    int a;
    int b;
    int c;
    int d;
    int kk;
    int na;
    int nb;
    int px;
    int py;
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty stack without start, extremes, collinear pops.
    send_point(16'h8000, 16'h8000, 1'b0, 1'b1);
    send_point(16'h7fff, 16'h7fff, 1'b0, 1'b1);
    send_point(16'h7fff, 16'h8000, 1'b0, 1'b1);
    send_point(16'h8000, 16'h7fff, 1'b0, 1'b0);
    send_point(16'h0000, 16'h0000, 1'b1, 1'b1);
    send_point(16'h0000, 16'h0000, 1'b0, 1'b1);
    send_point(16'd10, 16'd0, 1'b0, 1'b1);
    send_point(16'd20, 16'd0, 1'b0, 1'b1);
    send_point(16'd30, 16'd10, 1'b0, 1'b1);
    send_point(16'd40, 16'hfff6, 1'b0, 1'b1);
    send_point(16'hffff, 16'hffff, 1'b1, 1'b0);
    send_point(16'h5555, 16'haaaa, 1'b0, 1'b1);
    send_point(16'haaaa, 16'h5555, 1'b0, 1'b1);
    // Hold off until all results are back.
    drain();

    // Fill the stack past capacity: edge slopes walk the order-42 Farey fractions
    // from -1 up to 1, so every turn is strictly left.
    a = 0;
    b = 1;
    c = 1;
    d = 42;
    fa[0] = 0;
    fb[0] = 1;
    nf = 1;
    while (c <= 42) begin
      kk = (42 + b) / d;
      na = c;
      nb = d;
      c = kk * c - a;
      d = kk * d - b;
      a = na;
      b = nb;
      fa[nf] = a;
      fb[nf] = b;
      nf++;
    end
    px = -32000;
    py = 0;
    send_point(16'(px), 16'(py), 1'b1, 1'b0);
    n = 0;
    for (i = nf - 1; i >= 1 && n < 1030; i--) begin
      px += fb[i];
      py -= fa[i];
      n++;
      send_point(16'(px), 16'(py), 1'b0, (n % 50) == 0);
    end
    px += 1;
    n++;
    send_point(16'(px), 16'(py), 1'b0, (n % 50) == 0);
    for (i = 1; i < nf && n < 1030; i++) begin
      px += fb[i];
      py += fa[i];
      n++;
      send_point(16'(px), 16'(py), 1'b0, (n % 50) == 0);
    end
    drain();

    // Extreme-coordinate segments, with the total accumulated on every word.
    send_point(16'h8000, 16'h0000, 1'b1, 1'b1);
    send_point(16'h7fff, 16'h7fff, 1'b0, 1'b1);
    for (i = 0; i < 40; i++) send_point(16'h7fff, 16'h8000, 1'b0, 1'b1);

    random_run(100, 1'b1);
    random_run(300, 1'b0);
    drain();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("convex_chain_length_accumulator_top regression: pass");
    end else begin
      $display("convex_chain_length_accumulator_top regression: fail");
    end
    $finish;
  end
endmodule

>>> filelist.f
design/cclacc_pkg.sv
design/cclacc_ctrl.sv
design/cclacc_dp.sv
design/convex_chain_length_accumulator_top.sv
dv/tb_convex_chain_length_accumulator_top.sv
